// ===== hdl/brw_pkg.sv =====
// package: shared types and constants for the bragg ray reflection weight core
package brw_pkg;

  localparam int unsigned KIND_W = 2;
  localparam logic [1:0] KIND_RAY = 2'd0;
  localparam logic [1:0] KIND_LATTICE = 2'd1;
  localparam logic [1:0] KIND_SPECTRUM = 2'd2;

  localparam logic REG_LATTICE_COUNT = 1'b0;
  localparam logic REG_SPECTRUM_LENGTH = 1'b1;

  localparam int unsigned IN_DATA_W = 200;
  localparam int unsigned OUT_DATA_W = 168;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_DOT,
    ST_SUM,
    ST_SCALE,
    ST_ROUND,
    ST_RANGE,
    ST_SEARCH,
    ST_PICK,
    ST_EMIT
  } brw_state_t;

  typedef struct packed {
    logic load_ray;
    logic rd_lattice;
    logic dot_step;
    logic sum_step;
    logic scale_step;
    logic round_step;
    logic search_init;
    logic search_step;
    logic emit;
  } brw_cmd_t;

  typedef struct packed {
    logic search_done;
    logic out_busy;
    logic last_lat;
    logic no_lattice;
  } brw_status_t;

endpackage

// ===== hdl/brw_ctrl.sv =====
// controller: sequences lattice vectors and the spectrum search for one ray
module brw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               ray_start,
  input  brw_pkg::brw_status_t status,
  output brw_pkg::brw_cmd_t  cmd,
  output logic               busy
);
  import brw_pkg::*;

  brw_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (ray_start && !status.no_lattice) state_next = ST_RD;
      ST_RD:     state_next = ST_DOT;
      ST_DOT:    state_next = ST_SUM;
      ST_SUM:    state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_RANGE;
      ST_RANGE:  state_next = ST_SEARCH;
      ST_SEARCH: if (status.search_done) state_next = ST_PICK;
      ST_PICK:   state_next = ST_EMIT;
      ST_EMIT:   if (!status.out_busy) state_next = status.last_lat ? ST_IDLE : ST_RD;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:   cmd.load_ray = ray_start;
      ST_RD:     cmd.rd_lattice = 1'b1;
      ST_DOT:    cmd.dot_step = 1'b1;
      ST_SUM:    cmd.sum_step = 1'b1;
      ST_SCALE:  cmd.scale_step = 1'b1;
      ST_ROUND:  cmd.round_step = 1'b1;
      ST_RANGE:  cmd.search_init = 1'b1;
      ST_SEARCH: cmd.search_step = 1'b1;
      ST_PICK:   cmd = '0;
      ST_EMIT:   cmd.emit = !status.out_busy;
      default:   cmd = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);

  a_emit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.out_busy) else $error("emit while output full");
  a_search_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && !status.search_done) |=> state == ST_SEARCH)
    else $error("search left early");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last_lat) |=> state == ST_IDLE)
    else $error("no return to idle");
endmodule

// ===== hdl/brw_datapath.sv =====
// datapath: stores, dot product, wavelength, mirror, spectrum search, output register
module brw_datapath #(
  parameter int LATTICE_DEPTH = 16,
  parameter int SPECTRUM_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  brw_pkg::brw_cmd_t            cmd,
  output brw_pkg::brw_status_t         status,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [8:0]                   cfg_data,
  input  logic                         load_we,
  input  logic [1:0]                   load_kind,
  input  logic [brw_pkg::IN_DATA_W-1:0] in_word,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [brw_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                         m_tlast
);
  import brw_pkg::*;

  localparam int LA_W = (LATTICE_DEPTH > 1) ? $clog2(LATTICE_DEPTH) : 1;
  localparam int SP_W = (SPECTRUM_DEPTH > 1) ? $clog2(SPECTRUM_DEPTH) : 1;
  localparam int LC_W = $clog2(LATTICE_DEPTH + 1);
  localparam int SC_W = $clog2(SPECTRUM_DEPTH + 1);

  logic [4:0] lattice_count;
  logic [8:0] spectrum_length;
  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_count <= 5'd1;
      spectrum_length <= 9'd1;
    end else if (cfg_we) begin
      if (cfg_index == REG_LATTICE_COUNT) lattice_count <= cfg_data[4:0];
      else spectrum_length <= cfg_data;
    end
  end

  logic [LC_W-1:0] n_lat;
  logic [SC_W-1:0] slen;
  always_comb begin
    if (32'(lattice_count) > LATTICE_DEPTH) n_lat = LC_W'(LATTICE_DEPTH);
    else n_lat = LC_W'(lattice_count);
    if (32'(spectrum_length) > SPECTRUM_DEPTH) slen = SC_W'(SPECTRUM_DEPTH);
    else slen = SC_W'(spectrum_length);
  end

  logic [7:0] idx;
  logic signed [15:0] in_dx, in_dy, in_dz;
  logic [19:0] in_d;
  logic [15:0] in_a, in_ti;
  logic signed [21:0] in_tw;
  assign idx = in_word[9:2];
  assign in_dx = in_word[25:10];
  assign in_dy = in_word[41:26];
  assign in_dz = in_word[57:42];
  assign in_d = in_word[77:58];
  assign in_a = in_word[93:78];
  assign in_tw = in_word[115:94];
  assign in_ti = in_word[131:116];

  logic [47:0] lat_dir [LATTICE_DEPTH];
  logic [35:0] lat_da [LATTICE_DEPTH];
  logic [37:0] spec [SPECTRUM_DEPTH];

  logic [LA_W-1:0] k;
  logic [47:0] dir_rd;
  logic [35:0] da_rd;

  always_ff @(posedge clk) begin
    if (load_we && load_kind == KIND_LATTICE && 32'(idx) < LATTICE_DEPTH) begin
      lat_dir[LA_W'(idx)] <= {in_dz, in_dy, in_dx};
      lat_da[LA_W'(idx)] <= {in_a, in_d};
    end
    if (cmd.rd_lattice) begin
      dir_rd <= lat_dir[k];
      da_rd <= lat_da[k];
    end
  end

  // ray registers
  logic signed [15:0] vx, vy, vz;
  logic [31:0] px, py;
  always_ff @(posedge clk) begin
    if (cmd.load_ray) begin
      vx <= in_dx; vy <= in_dy; vz <= in_dz;
      px <= in_word[163:132]; py <= in_word[195:164];
    end
  end

  logic [LC_W-1:0] kcnt;
  always_ff @(posedge clk) begin
    if (rst || cmd.load_ray) kcnt <= '0;
    else if (cmd.emit) kcnt <= kcnt + 1'b1;
  end
  assign k = kcnt[LA_W-1:0];
  assign status.last_lat = (kcnt + 1'b1 == n_lat);
  assign status.no_lattice = (n_lat == '0);

  logic signed [15:0] sx, sy, sz;
  assign sx = dir_rd[15:0];
  assign sy = dir_rd[31:16];
  assign sz = dir_rd[47:32];

  logic signed [31:0] px0, px1, px2;
  logic signed [33:0] dot;
  logic signed [55:0] wl_prod;
  logic signed [50:0] mx, my, mz;
  logic signed [21:0] wl;
  logic signed [15:0] ox, oy, oz;

  function automatic logic signed [22:0] rnd28(input logic signed [55:0] x);
    logic signed [56:0] y;
    y = 57'(x) + 57'sd134217728;
    return 23'(y >>> 28) ;
  endfunction

  function automatic logic signed [21:0] sat22(input logic signed [22:0] x);
    if (x > 23'sd2097151) return 22'sd2097151;
    if (x < -23'sd2097152) return 22'sh200000;
    return x[21:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
    if (x > 24'sd32767) return 16'sd32767;
    if (x < -24'sd32768) return 16'sh8000;
    return x[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.dot_step) begin
      px0 <= vx * sx; px1 <= vy * sy; px2 <= vz * sz;
    end
    if (cmd.sum_step) dot <= 34'(px0) + 34'(px1) + 34'(px2);
    if (cmd.scale_step) begin
      wl_prod <= -(56'(signed'({1'b0, da_rd[19:0]})) * 56'(dot)) <<< 1;
      mx <= -(51'(sx) * 51'(dot)) <<< 1;
      my <= -(51'(sy) * 51'(dot)) <<< 1;
      mz <= -(51'(sz) * 51'(dot)) <<< 1;
    end
    if (cmd.round_step) begin
      wl <= sat22(rnd28(wl_prod));
      ox <= sat16(24'(vx) + 24'(rnd28(56'(mx))));
      oy <= sat16(24'(vy) + 24'(rnd28(56'(my))));
      oz <= sat16(24'(vz) + 24'(rnd28(56'(mz))));
    end
  end

  // spectrum memory, one registered read port; linear search for first >= wl
  always_ff @(posedge clk) begin
    if (load_we && load_kind == KIND_SPECTRUM && 32'(idx) < SPECTRUM_DEPTH)
      spec[SP_W'(idx)] <= {in_ti, in_tw};
  end

  logic [SC_W-1:0] sidx;
  logic [37:0] spec_rd;
  logic [SP_W-1:0] raddr;
  logic rd_valid;
  logic found;
  logic [15:0] hit_int;
  logic signed [21:0] first_wl;
  logic [1:0] rphase;
  logic in_range;
  logic [31:0] inten;

  // phases: 0 capture first while reading last, 1 capture last, 2 scan
  always_comb begin
    if (cmd.search_init) raddr = '0;
    else if (rphase == 2'd0) raddr = SP_W'(slen - 1'b1);
    else raddr = sidx[SP_W-1:0];
  end

  always_ff @(posedge clk) begin
    spec_rd <= spec[raddr];
  end

  logic signed [21:0] rd_wl;
  assign rd_wl = spec_rd[21:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rphase <= '0; sidx <= '0; found <= 1'b0; rd_valid <= 1'b0; in_range <= 1'b0;
    end else if (cmd.search_init) begin
      rphase <= 2'd0; sidx <= '0; found <= 1'b0; rd_valid <= 1'b0; in_range <= 1'b0;
    end else if (cmd.search_step) begin
      unique case (rphase)
        2'd0: begin
          first_wl <= rd_wl;
          rphase <= 2'd1;
        end
        2'd1: begin
          in_range <= (slen != '0) && wl >= first_wl && wl <= rd_wl;
          rphase <= 2'd2;
          rd_valid <= 1'b1;
          sidx <= sidx + 1'b1;
        end
        default: begin
          rd_valid <= 1'b1;
          if (!found && rd_valid) begin
            if (rd_wl >= wl) begin
              found <= 1'b1;
              hit_int <= spec_rd[37:22];
            end
          end
          if (sidx != slen) sidx <= sidx + 1'b1;
        end
      endcase
    end
  end

  // in the scan phase spec_rd holds entry sidx - 1; ends at a hit, when out of range or past the last entry
  logic scan_end;
  assign scan_end = rphase == 2'd2 && rd_valid &&
                    (found || !in_range || (rd_wl >= wl) || sidx == slen);
  logic last_seen;
  always_ff @(posedge clk) begin
    if (rst || cmd.search_init) last_seen <= 1'b0;
    else if (cmd.search_step && rphase == 2'd2 && rd_valid && sidx == slen)
      last_seen <= 1'b1;
  end
  assign status.search_done = scan_end && (found || !in_range || rd_wl >= wl || last_seen);

  logic hit;
  logic [15:0] hit_val;
  always_comb begin
    hit = found;
    hit_val = hit_int;
    if (!found && rd_wl >= wl) begin
      hit = 1'b1;
      hit_val = spec_rd[37:22];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_step && status.search_done)
      inten <= (in_range && hit) ? 32'(hit_val) * 32'(da_rd[35:20]) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.emit) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (cmd.emit) begin
      m_tdata <= {2'b00, py, px, oz, oy, ox, inten, wl};
      m_tlast <= status.last_lat;
    end
  end
  assign status.out_busy = m_tvalid && !m_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    status.out_busy |=> m_tvalid) else $error("word dropped");
  a_idx_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_lattice |-> kcnt < n_lat) else $error("lattice index past count");
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !in_range) |-> inten == 32'd0) else $error("out of range weight");
endmodule

// ===== hdl/bragg_ray_reflection_weight_core.sv =====
// top level: bragg ray reflection weight core
// a ray is accepted only while idle and yields one word per lattice vector, lattice_count capped at LATTICE_DEPTH
// per lattice vector: states RD, DOT, SUM, SCALE, ROUND, RANGE, then the spectrum scan in SEARCH, PICK and EMIT
// with lattice_count 0 a ray is taken but gives no word; loads are also accepted only while idle
// a ray blocks the input until its last word enters the output register; stalls add cycles
// reset (rst, synchronous) sets lattice_count and spectrum_length to 1, stores stay unwritten
module bragg_ray_reflection_weight_core #(
  parameter int LATTICE_DEPTH = 16,
  parameter int SPECTRUM_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // kind, entry_index, dir_x, dir_y, dir_z, plane_spacing, amplitude,
  // table_wavelength, table_intensity, pos_x, pos_y
  input  logic [brw_pkg::IN_DATA_W-1:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // wavelength, intensity, out_dir_x, out_dir_y, out_dir_z, out_pos_x, out_pos_y
  output logic [brw_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [8:0]   cfg_data
);
  import brw_pkg::*;

  brw_cmd_t cmd;
  brw_status_t status;
  logic busy, acc, ray_start;

  assign s_tready = !busy;
  assign acc = s_tvalid && s_tready;
  assign ray_start = acc && s_tdata[1:0] == KIND_RAY;

  brw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .ray_start(ray_start), .status(status),
    .cmd(cmd), .busy(busy)
  );

  brw_datapath #(.LATTICE_DEPTH(LATTICE_DEPTH), .SPECTRUM_DEPTH(SPECTRUM_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .load_we(acc), .load_kind(s_tdata[1:0]), .in_word(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );
endmodule

// ===== tb/bragg_ray_reflection_weight_core_test.sv =====
// testbench: bragg ray reflection weight core, directed table then random phases with prediction
module bragg_ray_reflection_weight_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import brw_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int LAT_N = 16;
  localparam int SPEC_N = 256;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 300;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] idx;
    logic signed [15:0] dx, dy, dz;
    logic [19:0] spacing;
    logic [15:0] amp;
    logic signed [21:0] wl;
    logic [15:0] inten;
    logic signed [31:0] px, py;
  } item_t;

  typedef struct {
    logic signed [21:0] wl;
    logic [31:0] inten;
    logic signed [15:0] dx, dy, dz;
    logic signed [31:0] px, py;
    logic last;
  } reflection_t;

  typedef struct {
    bit is_cfg;
    logic cfg_idx;
    logic [8:0] cfg_val;
    item_t it;
    bit has_exp;
    reflection_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;

  bragg_ray_reflection_weight_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor copy of the block state
  logic signed [15:0] lat_dir [LAT_N][3];
  logic [19:0] lat_spacing [LAT_N];
  logic [15:0] lat_amp [LAT_N];
  logic signed [21:0] spec_wl [SPEC_N];
  logic [15:0] spec_inten [SPEC_N];
  logic [4:0] lattice_count = 5'd1;
  logic [8:0] spectrum_length = 9'd1;

  reflection_t reflections_due[$];
  row_t dir_tab[$];
  int mismatches = 0;
  int results_seen = 0;
  int rays_sent = 0;
  int items_sent = 0;
  int phases_run = 0;
  int idle_cycles = 0;
  bit hold_done = 0;

  function automatic longint rnd28(longint x);
    return (x + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic void predict_word(item_t it);
    int n, slen;
    longint dot, l, r;
    longint v[3];
    logic [31:0] inten;
    reflection_t e;
    case (it.kind)
      KIND_LATTICE: begin
        if (it.idx < LAT_N) begin
          lat_dir[it.idx][0] = it.dx;
          lat_dir[it.idx][1] = it.dy;
          lat_dir[it.idx][2] = it.dz;
          lat_spacing[it.idx] = it.spacing;
          lat_amp[it.idx] = it.amp;
        end
      end
      KIND_SPECTRUM: begin
        spec_wl[it.idx] = it.wl;
        spec_inten[it.idx] = it.inten;
      end
      KIND_RAY: begin
        n = lattice_count > LAT_N ? LAT_N : lattice_count;
        slen = spectrum_length > SPEC_N ? SPEC_N : spectrum_length;
        v[0] = it.dx;
        v[1] = it.dy;
        v[2] = it.dz;
        for (int k = 0; k < n; k++) begin
          dot = v[0] * lat_dir[k][0] + v[1] * lat_dir[k][1] + v[2] * lat_dir[k][2];
          l = rnd28(-2 * longint'(lat_spacing[k]) * dot);
          l = clamp(l, -(64'sd1 <<< 21), (64'sd1 <<< 21) - 1);
          inten = '0;
          if (slen > 0 && l >= spec_wl[0] && l <= spec_wl[slen-1]) begin
            for (int i = 0; i < slen; i++) begin
              if (spec_wl[i] >= l) begin
                inten = spec_inten[i] * lat_amp[k];
                break;
              end
            end
          end
          e.wl = l[21:0];
          e.inten = inten;
          r = clamp(v[0] + rnd28(-2 * longint'(lat_dir[k][0]) * dot), -32768, 32767);
          e.dx = r[15:0];
          r = clamp(v[1] + rnd28(-2 * longint'(lat_dir[k][1]) * dot), -32768, 32767);
          e.dy = r[15:0];
          r = clamp(v[2] + rnd28(-2 * longint'(lat_dir[k][2]) * dot), -32768, 32767);
          e.dz = r[15:0];
          e.px = it.px;
          e.py = it.py;
          e.last = (k + 1 == n);
          reflections_due.push_back(e);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic item_t mk(logic [1:0] kind, logic [7:0] idx, int dx, int dy, int dz,
                               int spacing, int amp, int wl, int inten, int px, int py);
    item_t it;
    it.kind = kind;
    it.idx = idx;
    it.dx = dx;
    it.dy = dy;
    it.dz = dz;
    it.spacing = spacing;
    it.amp = amp;
    it.wl = wl;
    it.inten = inten;
    it.px = px;
    it.py = py;
    return it;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sdir();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic int swl();
    return int'($urandom_range(0, 2621440)) - 1310720;
  endfunction

  task automatic send(item_t it, bit typed, reflection_t exp);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, it.py, it.px, it.inten, it.wl, it.amp, it.spacing,
                it.dz, it.dy, it.dx, it.idx, it.kind};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (it.kind == KIND_RAY) rays_sent++;
    if (typed) reflections_due.push_back(exp);
    else predict_word(it);
    if (gap_len() > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (reflections_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LATTICE_COUNT) lattice_count = val[4:0];
    else spectrum_length = val;
  endtask

  function automatic void add_item(item_t it);
    row_t r;
    r.is_cfg = 0;
    r.it = it;
    r.has_exp = 0;
    dir_tab.push_back(r);
  endfunction

  function automatic void add_cfg(logic idx, int val);
    row_t r;
    r.is_cfg = 1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    r.has_exp = 0;
    dir_tab.push_back(r);
  endfunction

  function automatic void add_checked(item_t it, int wl, longint inten, int dx, int dy, int dz);
    row_t r;
    r.is_cfg = 0;
    r.it = it;
    r.has_exp = 1;
    r.exp.wl = wl;
    r.exp.inten = inten;
    r.exp.dx = dx;
    r.exp.dy = dy;
    r.exp.dz = dz;
    r.exp.px = it.px;
    r.exp.py = it.py;
    r.exp.last = 1'b1;
    dir_tab.push_back(r);
  endfunction

  // receiver: random stalls, a few long ones, plus one long hold-off
  always @(negedge clk) begin
    if (!hold_done && results_seen >= 40) begin
      hold_done = 1;
      m_tready <= 1'b0;
      repeat (500) @(negedge clk);
    end else if ($urandom_range(0, 199) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(20, 60)) @(negedge clk);
    end
    m_tready <= $urandom_range(0, 99) < 70;
  end

  always @(posedge clk) begin
    reflection_t e;
    if (m_tvalid && m_tready) begin
      results_seen++;
      if (reflections_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h last %b", m_tdata, m_tlast);
      end else begin
        e = reflections_due.pop_front();
        if (m_tdata[21:0] !== e.wl || m_tdata[53:22] !== e.inten ||
            m_tdata[69:54] !== e.dx || m_tdata[85:70] !== e.dy ||
            m_tdata[101:86] !== e.dz || m_tdata[133:102] !== e.px ||
            m_tdata[165:134] !== e.py || m_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp wl %0d int %0d dir %0d %0d %0d pos %h %h last %b",
                     e.wl, e.inten, e.dx, e.dy, e.dz, e.px, e.py, e.last);
            $display("         got wl %0d int %0d dir %0d %0d %0d pos %h %h last %b",
                     $signed(m_tdata[21:0]), m_tdata[53:22], $signed(m_tdata[69:54]),
                     $signed(m_tdata[85:70]), $signed(m_tdata[101:86]),
                     m_tdata[133:102], m_tdata[165:134], m_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d words pending", reflections_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    reflection_t none;
    item_t it;
    int lc, sl, n_items, p;
    bit big;
    none = '{default: '0};

    add_item(mk(KIND_LATTICE, 0, 16384, 0, 0, 65536, 65535, 0, 0, 0, 0));
    add_item(mk(KIND_SPECTRUM, 0, 0, 0, 0, 0, 0, 0, 65535, 0, 0));
    add_checked(mk(KIND_RAY, 0, -16384, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000),
                131072, 0, 16384, 0, 0);
    add_checked(mk(KIND_RAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, -1), 0, 64'd4294836225, 0, 0, 0);
    add_item(mk(KIND_UNUSED, 8'hff, -1, -1, -1, 655359, 65535, -1, 65535, -1, -1));
    add_item(mk(KIND_LATTICE, 200, 16384, 16384, 16384, 655359, 65535, 0, 0, 0, 0));
    add_item(mk(KIND_LATTICE, 1, 16384, 16384, 16384, 655359, 1, 0, 0, 0, 0));
    add_item(mk(KIND_LATTICE, 15, -16384, -16384, -16384, 0, 0, 0, 0, 0, 0));
    add_item(mk(KIND_SPECTRUM, 255, 0, 0, 0, 0, 0, 1310720, 1, 0, 0));
    add_item(mk(KIND_SPECTRUM, 1, 0, 0, 0, 0, 0, -1310720, 2, 0, 0));
    add_item(mk(KIND_SPECTRUM, 2, 0, 0, 0, 0, 0, 1310720, 3, 0, 0));
    add_cfg(REG_LATTICE_COUNT, 2);
    add_cfg(REG_SPECTRUM_LENGTH, 3);
    add_item(mk(KIND_RAY, 0, 16384, 16384, 16384, 0, 0, 0, 0, 5, 6));
    add_item(mk(KIND_RAY, 0, -16384, -16384, -16384, 0, 0, 0, 0, 7, 8));
    add_cfg(REG_LATTICE_COUNT, 0);
    add_item(mk(KIND_RAY, 0, 100, -200, 300, 0, 0, 0, 0, 9, 10));
    add_cfg(REG_LATTICE_COUNT, 1);
    add_cfg(REG_SPECTRUM_LENGTH, 0);
    add_item(mk(KIND_RAY, 0, 0, 0, 0, 0, 0, 0, 0, 11, 12));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain();
        write_reg(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
      end else begin
        send(dir_tab[i].it, dir_tab[i].has_exp, dir_tab[i].exp);
      end
    end

    // fill every store entry, spectrum ascending
    for (int i = 0; i < LAT_N; i++)
      send(mk(KIND_LATTICE, i, sdir(), sdir(), sdir(),
              $urandom_range(0, 1) ? $urandom_range(0, 65536) : $urandom_range(0, 655359),
              $urandom_range(0, 65535), 0, 0, 0, 0), 0, none);
    for (int i = 0; i < SPEC_N; i++)
      send(mk(KIND_SPECTRUM, i, 0, 0, 0, 0, 0, -1310720 + i * 10280 + $urandom_range(0, 9000),
              $urandom_range(0, 65535), 0, 0), 0, none);

    while (items_sent < 480) begin
      drain();
      case (phases_run)
        0: begin lc = 31; sl = 511; end
        1: begin lc = 16; sl = 256; end
        2: begin lc = 0; sl = 0; end
        default: begin
          p = $urandom_range(0, 9);
          lc = p == 0 ? 0 : (p == 1 ? 31 : $urandom_range(1, 16));
          p = $urandom_range(0, 9);
          sl = p == 0 ? 0 : (p < 8 ? $urandom_range(1, 20) : $urandom_range(64, 300));
        end
      endcase
      write_reg(REG_LATTICE_COUNT, lc);
      write_reg(REG_SPECTRUM_LENGTH, sl);
      phases_run++;
      big = sl >= 64 && lc != 0;
      n_items = big ? 6 : 40;
      for (int j = 0; j < n_items; j++) begin
        p = $urandom_range(0, 99);
        if (p < 75 || big)
          it = mk(KIND_RAY, $urandom, sdir(), sdir(), sdir(), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
        else if (p < 85)
          it = mk(KIND_LATTICE, $urandom_range(0, 255), sdir(), sdir(), sdir(),
                  $urandom_range(0, 655359), $urandom_range(0, 65535), 0, 0, 0, 0);
        else if (p < 95)
          it = mk(KIND_SPECTRUM, $urandom_range(0, 255), 0, 0, 0, 0, 0, swl(),
                  $urandom_range(0, 65535), 0, 0);
        else
          it = mk(KIND_UNUSED, $urandom, sdir(), sdir(), sdir(), 0, 0, 0, 0, 0, 0);
        send(it, 0, none);
      end
    end

    drain();
    $display("sent %0d words (%0d rays) over %0d register settings, checked %0d results",
             items_sent, rays_sent, phases_run + 4, results_seen);
    if (mismatches == 0 && reflections_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d words pending", mismatches, reflections_due.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/brw_pkg.sv
hdl/brw_ctrl.sv
hdl/brw_datapath.sv
hdl/bragg_ray_reflection_weight_core.sv
tb/bragg_ray_reflection_weight_core_test.sv
